// ===== hw/rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg: shared definitions for frame pixel statistics
// Pixel, counter and sum widths, register map and configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package fps_pkg;

  // Pixels in one input word
  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned PIX_W     = 12;

  // Result and accumulator widths
  localparam int unsigned CNT_W     = 25;
  localparam int unsigned SUM_W     = 37;
  localparam int unsigned SUM_OUT_W = 36;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_DIM_W  = 13;

  // Default dimension bound for the top level
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [CFG_DIM_W-1:0] dim_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_HEIGHT    = 3'd0,
    CFG_FRAME_WIDTH     = 3'd1,
    CFG_WHITE_THRESHOLD = 3'd2,
    CFG_BLACK_THRESHOLD = 3'd3,
    CFG_SINGLE_MODE     = 3'd4
  } cfg_reg_e;

  // Configuration reset values
  localparam dim_t RST_FRAME_HEIGHT    = 13'd1;
  localparam dim_t RST_FRAME_WIDTH     = 13'd8;
  localparam pix_t RST_WHITE_THRESHOLD = 12'd4000;
  localparam pix_t RST_BLACK_THRESHOLD = 12'd95;
  localparam logic RST_SINGLE_MODE     = 1'b1;

endpackage : fps_pkg

`default_nettype wire

// ===== hw/rtl/frame_pixel_statistics.sv =====
// ----------------------------------------------------------------------------
// frame_pixel_statistics: per-frame black/white count, min, max and sum
// Accumulates statistics over words of eight pixels and reports them once per
// frame, on the last word of the frame.
// ----------------------------------------------------------------------------
// The block takes one word of eight 12-bit pixels per transfer and sustains
// one word per clock. A word first lands in an input register; in the next
// cycle a single combinational pass classifies every lane against the white
// and black thresholds, updates the per-lane minimum and maximum, and adds the
// word into the running sum. When the word closes the frame (last word of the
// last row), the pass also folds the eight lanes into a global min and max and
// loads the result register, then clears all statistics, so each result
// passes the input and result registers. Input flow stops only when a
// frame-closing word sits in the input register while the result register
// still holds an untaken result; throughput is otherwise set by the input
// register alone. A row is ceil(frame_width / 8) words; the position counter
// steps in pixels, so no divider is needed. Zero or oversized dimensions are
// clamped to 1..MAX_DIM. In single-pixel mode only lane 0 is counted and the
// remaining lanes keep whatever they held. Configuration writes are accepted
// in every cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_pixel_statistics #(
  parameter int unsigned MAX_DIM = fps_pkg::MAX_DIM_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  // Configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fps_pkg::CFG_DATA_W-1:0] cfg_data_i,

  // Pixel word channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_0_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_1_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_2_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_3_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_4_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_5_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_6_i,
  input  logic [fps_pkg::PIX_W-1:0]      pixel_7_i,

  // Frame result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fps_pkg::CNT_W-1:0]      black_count_o,
  output logic [fps_pkg::CNT_W-1:0]      white_count_o,
  output logic [fps_pkg::PIX_W-1:0]      frame_min_o,
  output logic [fps_pkg::PIX_W-1:0]      frame_max_o,
  output logic [fps_pkg::SUM_OUT_W-1:0]  pixel_sum_o
);

  import fps_pkg::*;

  // Pixel column and row counters; the column counter steps by NUM_LANES
  localparam int unsigned COL_W   = $clog2(MAX_DIM);
  localparam int unsigned ROW_W   = $clog2(MAX_DIM);
  localparam int unsigned EXT_W   = (COL_W + 1 > CFG_DIM_W) ? COL_W + 1 : CFG_DIM_W;
  localparam int unsigned LCNT_W  = $clog2(NUM_LANES + 1);
  localparam int unsigned WSUM_W  = PIX_W + $clog2(NUM_LANES);

  typedef logic [EXT_W-1:0] ext_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  dim_t height_q, width_q;
  pix_t white_thr_q, black_thr_q;
  logic single_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q    <= RST_FRAME_HEIGHT;
      width_q     <= RST_FRAME_WIDTH;
      white_thr_q <= RST_WHITE_THRESHOLD;
      black_thr_q <= RST_BLACK_THRESHOLD;
      single_q    <= RST_SINGLE_MODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_FRAME_HEIGHT:    height_q    <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_FRAME_WIDTH:     width_q     <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_WHITE_THRESHOLD: white_thr_q <= cfg_data_i[PIX_W-1:0];
        CFG_BLACK_THRESHOLD: black_thr_q <= cfg_data_i[PIX_W-1:0];
        CFG_SINGLE_MODE:     single_q    <= cfg_data_i[0];
        default: ;  // writes beyond the register map are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  pix_t s1_pix_q [NUM_LANES];
  pix_t in_pix   [NUM_LANES];
  logic in_xfer, s1_go, res_load;

  assign in_pix[0] = pixel_0_i;
  assign in_pix[1] = pixel_1_i;
  assign in_pix[2] = pixel_2_i;
  assign in_pix[3] = pixel_3_i;
  assign in_pix[4] = pixel_4_i;
  assign in_pix[5] = pixel_5_i;
  assign in_pix[6] = pixel_6_i;
  assign in_pix[7] = pixel_7_i;

  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_pix_q <= in_pix;
    end
  end

  // --------------------------------------------------------------------------
  // Statistics state
  // --------------------------------------------------------------------------
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] black_total_q, black_total_d;
  logic [CNT_W-1:0] white_total_q, white_total_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  pix_t lane_min_q [NUM_LANES];
  pix_t lane_max_q [NUM_LANES];
  pix_t lane_min_d [NUM_LANES];
  pix_t lane_max_d [NUM_LANES];

  // Per-word classification and reduction
  logic [LCNT_W-1:0] word_white, word_black;
  logic [WSUM_W-1:0] word_sum;
  logic              lane_on;
  pix_t              gmin, gmax;
  logic [CNT_W-1:0]  black_upd, white_upd;
  logic [SUM_W-1:0]  sum_upd;

  always_comb begin
    word_white = '0;
    word_black = '0;
    word_sum   = '0;
    for (int p = 0; p < NUM_LANES; p++) begin
      lane_on       = (p == 0) || !single_q;
      lane_min_d[p] = lane_min_q[p];
      lane_max_d[p] = lane_max_q[p];
      if (lane_on) begin
        if (s1_pix_q[p] > white_thr_q) begin
          word_white = word_white + LCNT_W'(1);
        end else if (s1_pix_q[p] < black_thr_q) begin
          word_black = word_black + LCNT_W'(1);
        end
        if (s1_pix_q[p] < lane_min_q[p]) lane_min_d[p] = s1_pix_q[p];
        if (s1_pix_q[p] > lane_max_q[p]) lane_max_d[p] = s1_pix_q[p];
        word_sum = word_sum + WSUM_W'(s1_pix_q[p]);
      end
    end
    black_upd = black_total_q + CNT_W'(word_black);
    white_upd = white_total_q + CNT_W'(word_white);
    sum_upd   = sum_q + SUM_W'(word_sum);

    // Fold lanes into the frame min and max; single mode reports lane 0 only
    gmin = lane_min_d[0];
    gmax = lane_max_d[0];
    if (!single_q) begin
      for (int p = 1; p < NUM_LANES; p++) begin
        if (lane_min_d[p] < gmin) gmin = lane_min_d[p];
        if (lane_max_d[p] > gmax) gmax = lane_max_d[p];
      end
    end
  end

  // Frame position: clamp dimensions and detect row and frame end
  ext_t width_ext, height_ext, width_c, height_c;
  ext_t col_next, row_next;
  logic row_end, frame_end;

  always_comb begin
    width_ext  = EXT_W'(width_q);
    height_ext = EXT_W'(height_q);
    if (width_ext == '0) begin
      width_c = EXT_W'(1);
    end else if (width_ext > EXT_W'(MAX_DIM)) begin
      width_c = EXT_W'(MAX_DIM);
    end else begin
      width_c = width_ext;
    end
    if (height_ext == '0) begin
      height_c = EXT_W'(1);
    end else if (height_ext > EXT_W'(MAX_DIM)) begin
      height_c = EXT_W'(MAX_DIM);
    end else begin
      height_c = height_ext;
    end
    col_next  = EXT_W'(col_q) + EXT_W'(NUM_LANES);
    row_next  = EXT_W'(row_q) + EXT_W'(1);
    row_end   = col_next >= width_c;
    frame_end = row_end && (row_next >= height_c);
  end

  // A frame-closing word needs a free result slot; all others always advance
  assign s1_go    = s1_valid_q && !(frame_end && out_valid_o && !out_ready_i);
  assign res_load = s1_go && frame_end;

  always_comb begin
    col_d         = col_q;
    row_d         = row_q;
    black_total_d = black_total_q;
    white_total_d = white_total_q;
    sum_d         = sum_q;
    if (s1_go) begin
      if (frame_end) begin
        col_d         = '0;
        row_d         = '0;
        black_total_d = '0;
        white_total_d = '0;
        sum_d         = '0;
      end else begin
        black_total_d = black_upd;
        white_total_d = white_upd;
        sum_d         = sum_upd;
        if (row_end) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_next[COL_W-1:0];
        end
      end
    end
  end

  // Lane min/max registers: advance on a processed word, reset at frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_LANES; p++) begin
        lane_min_q[p] <= '1;
        lane_max_q[p] <= '0;
      end
    end else if (s1_go) begin
      for (int p = 0; p < NUM_LANES; p++) begin
        lane_min_q[p] <= frame_end ? '1 : lane_min_d[p];
        lane_max_q[p] <= frame_end ? '0 : lane_max_d[p];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      black_total_q <= '0;
      white_total_q <= '0;
      sum_q         <= '0;
    end else begin
      col_q         <= col_d;
      row_q         <= row_d;
      black_total_q <= black_total_d;
      white_total_q <= white_total_d;
      sum_q         <= sum_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      black_count_o <= black_upd;
      white_count_o <= white_upd;
      frame_min_o   <= gmin;
      frame_max_o   <= gmax;
      pixel_sum_o   <= sum_upd[SUM_OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A delivered frame leaves the position and totals cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> (col_q == '0 && row_q == '0 && black_total_q == '0 &&
                  white_total_q == '0 && sum_q == '0))
    else $error("statistics not cleared after frame result");

  // Input stalls only behind a waiting result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && frame_end))
    else $error("input stalled without a pending result");

  // Column position stays inside the largest row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    EXT_W'(col_q) < EXT_W'(MAX_DIM))
    else $error("column position out of range");

  // A new result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !res_load)
    else $error("result overwritten before transfer");

endmodule : frame_pixel_statistics

`default_nettype wire
